// ----- src/assert_macros.svh -----
// Assertion helpers used by the tick counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/dctc_pkg.sv -----
// ----------------------------------------------------------------------------
// dctc_pkg
// Types, control-store program and interval helpers for the dozonal tick
// counter.
// ----------------------------------------------------------------------------
package dctc_pkg;

  localparam int PHASE_W = 9;
  localparam int MS_W    = 9;

  localparam logic [PHASE_W-1:0] ACC_MOD = 9'd9;
  localparam logic [PHASE_W-1:0] RES_MOD = 9'd349;

  localparam logic [MS_W-1:0] IVL_346 = 9'd346;
  localparam logic [MS_W-1:0] IVL_347 = 9'd347;
  localparam logic [MS_W-1:0] IVL_348 = 9'd348;

  localparam logic [PHASE_W-1:0] ACC_LONG_A = 9'd3;
  localparam logic [PHASE_W-1:0] ACC_LONG_B = 9'd7;
  localparam logic [4:0]         RES_M5_VAL = 5'h01;
  localparam logic [6:0]         RES_M7_VAL = 7'h11;

  typedef logic [3:0] step_t;
  typedef logic [2:0] cond_t;
  typedef logic [1:0] cnt_op_t;
  typedef logic [1:0] ms_op_t;

  // sequencer steps
  localparam step_t S_WAIT = 4'd0;
  localparam step_t S_DISP = 4'd1;
  localparam step_t S_CHK  = 4'd2;
  localparam step_t S_INC  = 4'd3;
  localparam step_t S_SKIP = 4'd4;
  localparam step_t S_IVL  = 4'd5;
  localparam step_t S_LOAD = 4'd6;
  localparam step_t S_HOLD = 4'd7;
  localparam step_t S_OUT  = 4'd8;

  // jump conditions
  localparam cond_t C_NEXT     = 3'd0;
  localparam cond_t C_ALWAYS   = 3'd1;
  localparam cond_t C_NOT_ACC  = 3'd2;
  localparam cond_t C_LOAD     = 3'd3;
  localparam cond_t C_NOT_EXP  = 3'd4;
  localparam cond_t C_SKIP     = 3'd5;
  localparam cond_t C_OUT_BUSY = 3'd6;

  localparam cnt_op_t CNT_HOLD = 2'd0;
  localparam cnt_op_t CNT_LOAD = 2'd1;
  localparam cnt_op_t CNT_INC  = 2'd2;
  localparam cnt_op_t CNT_SKIP = 2'd3;

  localparam ms_op_t MS_HOLD = 2'd0;
  localparam ms_op_t MS_DEC  = 2'd1;
  localparam ms_op_t MS_NEW  = 2'd2;

  typedef struct packed {
    cond_t   cond;
    step_t   target;
    cnt_op_t cnt_op;
    ms_op_t  ms_op;
    logic    capture;
    logic    set_run;
    logic    ptr_clr;
    logic    upd_set;
    logic    upd_clr;
    logic    out_load;
  } ctrl_t;

  // control store: taken jump goes to target, otherwise to the next step
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = '0;
    unique case (s)
      S_WAIT: begin
        w.cond = C_NOT_ACC; w.target = S_WAIT; w.capture = 1'b1; w.upd_clr = 1'b1;
      end
      S_DISP: begin
        w.cond = C_LOAD; w.target = S_LOAD;
      end
      S_CHK: begin
        w.cond = C_NOT_EXP; w.target = S_HOLD;
      end
      S_INC: begin
        w.cond = C_NEXT; w.cnt_op = CNT_INC; w.ptr_clr = 1'b1; w.upd_set = 1'b1;
      end
      S_SKIP: begin
        w.cond = C_SKIP; w.target = S_SKIP; w.cnt_op = CNT_SKIP;
      end
      S_IVL: begin
        w.cond = C_ALWAYS; w.target = S_OUT; w.ms_op = MS_NEW;
      end
      S_LOAD: begin
        w.cond = C_ALWAYS; w.target = S_INC; w.cnt_op = CNT_LOAD; w.set_run = 1'b1;
      end
      S_HOLD: begin
        w.cond = C_NEXT; w.ms_op = MS_DEC;
      end
      S_OUT: begin
        w.cond = C_OUT_BUSY; w.target = S_OUT; w.out_load = 1'b1;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = S_WAIT;
      end
    endcase
    return w;
  endfunction

  // phase wraps at the modulus of the mode; out-of-range phases step to 0
  function automatic logic [PHASE_W-1:0] next_phase(input logic mode,
                                                    input logic [PHASE_W-1:0] p);
    logic [PHASE_W:0] inc;
    logic [PHASE_W:0] lim;
    inc = {1'b0, p} + {{PHASE_W{1'b0}}, 1'b1};
    lim = mode ? {1'b0, RES_MOD} : {1'b0, ACC_MOD};
    return (inc >= lim) ? '0 : inc[PHASE_W-1:0];
  endfunction

  function automatic logic [MS_W-1:0] interval(input logic mode,
                                               input logic [PHASE_W-1:0] p);
    logic long_ivl;
    if (mode) begin
      long_ivl = !p[0] || (p[4:0] == RES_M5_VAL) || (p[6:0] == RES_M7_VAL);
      return long_ivl ? IVL_347 : IVL_346;
    end
    long_ivl = (p == ACC_LONG_A) || (p == ACC_LONG_B);
    return long_ivl ? IVL_348 : IVL_347;
  endfunction

endpackage

// ----- src/dozonal_clock_tick_counter.sv -----
// ----------------------------------------------------------------------------
// dozonal_clock_tick_counter
// A tick that does not expire steps through dispatch, check, hold and output;
// an advance steps through increment, skip (repeated for each invalid digit),
// interval and output, set by the one-step-a-cycle control store.
// One word in flight at a time; the next word is taken only after the result loads.
// Synchronous active-low reset clears count, interval, phase and mode.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dozonal_clock_tick_counter #(
  parameter int DIGITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [31:0] in_load_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_count,
  output logic        out_updated
);
  import dctc_pkg::*;

  localparam int CW = 4 * DIGITS;
  localparam int PW = $clog2(DIGITS + 1);
  localparam int IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  step_t                step_r, step_nxt;
  logic                 mode_r;
  logic                 running_r, running_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [MS_W-1:0]      ms_left_r, ms_left_nxt;
  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  logic [PW-1:0]        ptr_r, ptr_nxt;
  logic                 upd_r, upd_nxt;
  logic                 op_r;
  logic [31:0]          ld_r;
  logic                 out_valid_r;
  logic [31:0]          out_count_r;
  logic                 out_updated_r;

  ctrl_t                uc;
  logic                 in_acc, out_busy, skip_ok, expire, jmp;
  logic [DIGITS-1:0][3:0] dig;
  logic [3:0]           cur_dig;
  logic [63:0]          ld64, cnt64;
  logic [PHASE_W-1:0]   phase_n;

  assign uc       = ucode(step_r);
  assign in_stall = (step_r != S_WAIT);
  assign in_acc   = in_valid && !in_stall;
  assign out_busy = out_valid_r && out_stall;
  assign expire   = running_r && (ms_left_r <= {{(MS_W-1){1'b0}}, 1'b1});

  // digit under the carry pointer; both low bits set means invalid, skip it
  assign dig     = count_r;
  assign cur_dig = dig[ptr_r[IW-1:0]];
  assign skip_ok = (ptr_r < PW'(DIGITS)) && (cur_dig[1:0] == 2'b11);

  always_comb begin
    ld64 = {32'b0, ld_r};
    cnt64 = '0;
    cnt64[CW-1:0] = count_r;
  end

  assign phase_n = next_phase(mode_r, phase_r);

  always_comb begin
    unique case (uc.cond)
      C_NEXT:     jmp = 1'b0;
      C_ALWAYS:   jmp = 1'b1;
      C_NOT_ACC:  jmp = !in_acc;
      C_LOAD:     jmp = !op_r;
      C_NOT_EXP:  jmp = !expire;
      C_SKIP:     jmp = skip_ok;
      C_OUT_BUSY: jmp = out_busy;
      default:    jmp = 1'b1;
    endcase
    step_nxt = jmp ? uc.target : step_r + step_t'(1);
  end

  always_comb begin
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    unique case (uc.cnt_op)
      CNT_HOLD: count_nxt = count_r;
      CNT_LOAD: count_nxt = ld64[CW-1:0];
      CNT_INC:  count_nxt = count_r + CW'(1);
      CNT_SKIP: begin
        if (skip_ok) begin
          count_nxt = count_r + (CW'(1) << {ptr_r, 2'b00});
          ptr_nxt   = ptr_r + PW'(1);
        end
      end
    endcase
    if (uc.ptr_clr) ptr_nxt = '0;
  end

  always_comb begin
    ms_left_nxt = ms_left_r;
    phase_nxt   = phase_r;
    unique case (uc.ms_op)
      MS_DEC: begin
        if (running_r) ms_left_nxt = ms_left_r - MS_W'(1);
      end
      MS_NEW: begin
        phase_nxt   = phase_n;
        ms_left_nxt = interval(mode_r, phase_n);
      end
      default: ms_left_nxt = ms_left_r;
    endcase
  end

  always_comb begin
    running_nxt = running_r || uc.set_run;
    upd_nxt     = upd_r;
    if (uc.upd_clr) upd_nxt = 1'b0;
    if (uc.upd_set) upd_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_WAIT;
      mode_r      <= 1'b0;
      running_r   <= 1'b0;
      count_r     <= '0;
      ms_left_r   <= '0;
      phase_r     <= '0;
      ptr_r       <= '0;
      upd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r    <= step_nxt;
      running_r <= running_nxt;
      count_r   <= count_nxt;
      ms_left_r <= ms_left_nxt;
      phase_r   <= phase_nxt;
      ptr_r     <= ptr_nxt;
      upd_r     <= upd_nxt;
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      if (uc.out_load && !out_busy) out_valid_r <= 1'b1;
      else if (!out_stall)          out_valid_r <= 1'b0;
    end
  end

  // item and result words
  always_ff @(posedge clk) begin
    if (uc.capture && in_acc) begin
      op_r <= in_opcode;
      ld_r <= in_load_value;
    end
    if (uc.out_load && !out_busy) begin
      out_count_r   <= cnt64[31:0];
      out_updated_r <= upd_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_count   = out_count_r;
  assign out_updated = out_updated_r;

  `ASSERT_NEXT(a_acc_disp, in_valid && !in_stall, step_r == S_DISP)
  `ASSERT_IMPL(a_ptr_range, 1'b1, ptr_r <= PW'(DIGITS))
  `ASSERT_IMPL(a_inc_running, step_r == S_INC, running_r)
  `ASSERT_IMPL(a_ivl_upd, step_r == S_IVL, upd_r)

endmodule

// ----- bench/dozonal_clock_tick_counter_test.sv -----
// ----------------------------------------------------------------------------
// dozonal_clock_tick_counter_test
// Self-checking bench for the dozonal tick counter. A behavioural copy of the
// count, interval and phase logic predicts every result word. Directed loads
// cover carries and bad digit codes. A long tick run goes through interval
// expiry in the resonator mode, and short mixed runs switch between modes.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module dozonal_clock_tick_counter_test;
  import dctc_pkg::*;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam logic MODE_ACCURATE  = 1'b0;
  localparam logic MODE_RESONATOR = 1'b1;

  localparam int ACC_STEPS = 9;
  localparam int RES_STEPS = 349;
  localparam int SETTLE    = 24;
  localparam int LIMIT     = 500000;

  typedef struct packed {
    logic [31:0] count;
    logic        updated;
  } count_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = OP_TICK;
  logic [31:0] in_load_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_count;
  logic        out_updated;

  // model state
  logic [31:0]        tick_count = '0;
  logic [MS_W-1:0]    ms_left = '0;
  logic [PHASE_W-1:0] phase = '0;
  logic               running = 1'b0;
  logic               res_mode = MODE_ACCURATE;

  count_rec_t count_queue[$];
  int  err_count = 0;
  int  cycle_count = 0;
  int  loads_sent = 0;
  int  ticks_sent = 0;
  int  advances_seen = 0;
  logic calm = 1'b0;

  dozonal_clock_tick_counter u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_load_value(in_load_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_count    (out_count),
    .out_updated  (out_updated)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("%0t: timed out after %0d cycles", $time, cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // +1, then carry over any digit whose two low bits are both set
  function automatic logic [31:0] dozonal_inc(input logic [31:0] v);
    logic [31:0] r;
    logic        done;
    r = v + 32'd1;
    done = 1'b0;
    for (int d = 0; d < 8; d++) begin
      if (!done) begin
        if (r[4*d +: 2] != 2'b11) done = 1'b1;
        else r = r + (32'd1 << (4*d));
      end
    end
    return r;
  endfunction

  task automatic pick_interval(output logic [MS_W-1:0] ivl);
    logic [PHASE_W:0] nxt;
    nxt = {1'b0, phase} + 1'b1;
    if (res_mode == MODE_RESONATOR) begin
      phase = (nxt >= RES_STEPS) ? '0 : nxt[PHASE_W-1:0];
      ivl = (!phase[0] || phase[4:0] == 5'h01 || phase[6:0] == 7'h11) ? 9'd347 : 9'd346;
    end else begin
      phase = (nxt >= ACC_STEPS) ? '0 : nxt[PHASE_W-1:0];
      ivl = (phase == 9'd3 || phase == 9'd7) ? 9'd348 : 9'd347;
    end
  endtask

  task automatic track_word(input logic op, input logic [31:0] val);
    count_rec_t rec;
    rec.updated = 1'b0;
    if (op == OP_LOAD) begin
      tick_count = dozonal_inc(val);
      running = 1'b1;
      pick_interval(ms_left);
      rec.updated = 1'b1;
    end else if (running) begin
      if (ms_left <= 1) begin
        tick_count = dozonal_inc(tick_count);
        pick_interval(ms_left);
        rec.updated = 1'b1;
      end else begin
        ms_left = ms_left - 1'b1;
      end
    end
    rec.count = tick_count;
    count_queue.push_back(rec);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) track_word(in_opcode, in_load_value);
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 20);
  end

  always @(posedge clk) begin : check_results
    count_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (count_queue.size() == 0) begin
        $display("%0t: unexpected word count=%h updated=%b", $time, out_count, out_updated);
        err_count++;
      end else begin
        want = count_queue.pop_front();
        if (out_count !== want.count) begin
          $display("%0t: count mismatch, expected %h got %h", $time, want.count, out_count);
          err_count++;
        end
        if (out_updated !== want.updated) begin
          $display("%0t: updated mismatch, expected %b got %b",
                   $time, want.updated, out_updated);
          err_count++;
        end
        if (out_updated === 1'b1) advances_seen++;
      end
    end
  end

  // valid is left high after acceptance so back-to-back words need no re-raise
  task automatic send_word(input logic op, input logic [31:0] val);
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_load_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_LOAD) loads_sent++;
    else ticks_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (count_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    wait_for_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    res_mode = m;
  endtask

  // mostly legal digits, biased to E for long carries; some raw words
  function automatic logic [31:0] random_count();
    logic [31:0] v;
    logic [3:0]  d;
    v = $urandom();
    if ($urandom_range(0, 3) != 0) begin
      for (int i = 0; i < 8; i++) begin
        d = $urandom_range(0, 15);
        if (d[1:0] == 2'b11) d = 4'hE;
        v[4*i +: 4] = d;
      end
    end
    return v;
  endfunction

  task automatic test_ticks_before_load();
    set_mode(MODE_ACCURATE);
    send_word(OP_TICK, 32'hFFFF_FFFF);
    send_word(OP_TICK, 32'h0000_0000);
  endtask

  task automatic test_load_carries();
    logic [31:0] vals[10];
    vals = '{32'h0000_0000, 32'h0000_0002, 32'hEEEE_EEEE, 32'hFFFF_FFFF, 32'h0000_0033,
             32'h0000_000B, 32'h3333_3332, 32'h0000_000E, 32'h0000_00F7, 32'h1245_689A};
    foreach (vals[i]) send_word(OP_LOAD, vals[i]);
    send_word(OP_TICK, $urandom());
    send_word(OP_TICK, $urandom());
  endtask

  // resonator phase runs past 8, then accurate mode must step it back to 0
  task automatic test_phase_out_of_range();
    set_mode(MODE_RESONATOR);
    repeat (10) send_word(OP_LOAD, random_count());
    set_mode(MODE_ACCURATE);
    send_word(OP_LOAD, random_count());
    send_word(OP_LOAD, random_count());
  endtask

  task automatic test_interval_expiry(input logic m);
    set_mode(m);
    send_word(OP_LOAD, random_count());
    calm = 1'b1;
    repeat (200) send_word(OP_TICK, $urandom());
    calm = 1'b0;
    repeat (152) send_word(OP_TICK, $urandom());
  endtask

  task automatic test_mode_mix();
    for (int k = 0; k < 4; k++) begin
      set_mode(k[0] ? MODE_RESONATOR : MODE_ACCURATE);
      repeat (30) begin
        if ($urandom_range(0, 1) == 0) send_word(OP_LOAD, random_count());
        else send_word(OP_TICK, $urandom());
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_ticks_before_load();
    test_load_carries();
    test_phase_out_of_range();
    test_interval_expiry(MODE_RESONATOR);
    test_mode_mix();
    wait_for_results();

    $display("Sent %0d loads and %0d ticks; %0d count advances checked.",
             loads_sent, ticks_sent, advances_seen);
    $display("Covered carries, bad digits, phase stepping back and interval expiry.");
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
